@@ sv/tgad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgad_pkg
// shared types and constants of the tga rle pixel decoder
// ----------------------------------------------------------------------------
package tgad_pkg;

  localparam int COORD_BITS_DEF = 12;   // default coordinate counter width
  localparam int FIFO_DEPTH_DEF = 4;    // default depth of the pixel queue
  localparam int CFG_BITS       = 13;   // widest configuration register
  localparam int CFG_IDX_BITS   = 3;
  localparam int RUN_CAP        = 64;   // run copies issued per byte at most
  localparam int RAW_MAX        = 127;  // largest header value of a raw packet
  localparam int OUT_COORD_BITS = 12;   // coordinate width on the output stream

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_RLE_MODE     = 3'd2,
    CFG_MIRROR_X     = 3'd3,
    CFG_MIRROR_Y     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic rle_mode;
    logic mirror_x;
    logic mirror_y;
  } mode_t;

endpackage

@@ sv/tgad_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgad_fifo
// small register queue between the byte front end and the pixel back end
// ----------------------------------------------------------------------------
module tgad_fifo #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(wr_en && full))
    else $error("tgad_fifo: write into full queue");
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("tgad_fifo: fill count beyond depth");

endmodule

@@ sv/tgad_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgad_front
// byte classifier: packet headers, colour assembly, run expansion and raster
// position tracking; issues at most one pixel per cycle into the queue, only
// while the queue has room
module tgad_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tgad_pkg::mode_t       mode,
  input  logic [COORD_BITS:0]   eff_w,
  input  logic [COORD_BITS:0]   eff_h,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_sof,
  input  logic                  q_full,
  output logic                  push,
  output logic [31:0]           push_color,
  output logic [COORD_BITS-1:0] push_col,
  output logic [COORD_BITS-1:0] push_row
);

  import tgad_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int NW = $clog2(RUN_CAP + 1);
  localparam logic [NW-1:0] RUN_CAP_N  = NW'(RUN_CAP);
  localparam logic [1:0]    LAST_PHASE = 2'd3;   // fourth byte of a pixel
  localparam logic [7:0]    RAW_MAX_B  = 8'(RAW_MAX);

  typedef enum logic [1:0] {
    S_ACCEPT,
    S_RUN,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [CB-1:0] col;
    logic [CB-1:0] row;
    logic          done;
  } pos_t;

  state_t        state, state_next;
  logic [1:0]    phase, phase_next;
  logic [23:0]   cbytes, cbytes_next;
  logic [31:0]   held, held_next;
  logic [7:0]    left, left_next;
  logic          is_raw, is_raw_next;
  logic          want_hdr, want_hdr_next;
  logic          run_pend, run_pend_next;
  logic          done, done_next;
  logic [CB-1:0] col, col_next;
  logic [CB-1:0] row, row_next;
  logic [NW-1:0] n, n_next;
  logic [7:0]    pend_byte, pend_byte_next;
  logic          pend_sof, pend_sof_next;
  logic          pend_v, pend_v_next;

  function automatic pos_t advance(input logic [CB-1:0] c, input logic [CB-1:0] r);
    pos_t          p;
    logic [CB-1:0] cn;
    logic [CB-1:0] rn;
    cn     = c + CB'(1);
    rn     = r + CB'(1);
    p.col  = cn;
    p.row  = r;
    p.done = 1'b0;
    if (cn == '0 || EW'(cn) >= eff_w) begin
      p.col = '0;
      p.row = rn;
      if (rn == '0 || EW'(rn) >= eff_h) begin
        p.done = 1'b1;
      end
    end
    return p;
  endfunction

  always_comb begin
    logic        go;
    logic [7:0]  b;
    logic        fs;
    logic [31:0] color;
    pos_t        ps;

    state_next     = state;
    phase_next     = phase;
    cbytes_next    = cbytes;
    held_next      = held;
    left_next      = left;
    is_raw_next    = is_raw;
    want_hdr_next  = want_hdr;
    run_pend_next  = run_pend;
    done_next      = done;
    col_next       = col;
    row_next       = row;
    n_next         = n;
    pend_byte_next = pend_byte;
    pend_sof_next  = pend_sof;
    pend_v_next    = pend_v;

    push       = 1'b0;
    push_color = held;
    push_col   = col;
    push_row   = row;
    in_ready   = (state == S_ACCEPT) && !q_full;

    go    = 1'b0;
    b     = in_byte;
    fs    = in_sof;
    color = '0;
    ps    = '0;

    case (state)
      S_ACCEPT: begin
        if (in_valid && in_ready) begin
          if (run_pend) begin
            // leftover run copies go out before this byte is looked at
            pend_byte_next = in_byte;
            pend_sof_next  = in_sof;
            pend_v_next    = 1'b1;
            n_next         = '0;
            state_next     = S_RUN;
          end else begin
            go = 1'b1;
          end
        end
      end
      S_RUN: begin
        if (!q_full) begin
          if (left != '0 && n != RUN_CAP_N && !done) begin
            push      = 1'b1;
            ps        = advance(col, row);
            col_next  = ps.col;
            row_next  = ps.row;
            done_next = ps.done;
            n_next    = n + NW'(1);
            left_next = left - 8'd1;
            if (ps.done) begin
              left_next     = '0;
              want_hdr_next = 1'b1;
              run_pend_next = 1'b0;
              phase_next    = '0;
              cbytes_next   = '0;
            end
          end else begin
            if (done || left == '0) begin
              left_next     = '0;
              want_hdr_next = 1'b1;
              run_pend_next = 1'b0;
            end else begin
              run_pend_next = 1'b1;
            end
            state_next = pend_v ? S_HOLD : S_ACCEPT;
          end
        end
      end
      S_HOLD: begin
        if (!q_full) begin
          go          = 1'b1;
          b           = pend_byte;
          fs          = pend_sof;
          pend_v_next = 1'b0;
          state_next  = S_ACCEPT;
        end
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase

    if (go) begin
      if (fs) begin
        phase_next    = '0;
        cbytes_next   = '0;
        held_next     = '0;
        left_next     = '0;
        is_raw_next   = 1'b0;
        want_hdr_next = 1'b1;
        run_pend_next = 1'b0;
        col_next      = '0;
        row_next      = '0;
        done_next     = 1'b0;
      end
      if (!done_next) begin
        if (mode.rle_mode && want_hdr_next) begin
          // packet header
          is_raw_next   = (b <= RAW_MAX_B);
          left_next     = (b <= RAW_MAX_B) ? b + 8'd1 : b - RAW_MAX_B;
          want_hdr_next = 1'b0;
          phase_next    = '0;
          cbytes_next   = '0;
        end else if (phase_next != LAST_PHASE) begin
          case (phase_next)
            2'd0:    cbytes_next        = {16'd0, b};
            2'd1:    cbytes_next[15:8]  = b;
            default: cbytes_next[23:16] = b;
          endcase
          phase_next = phase_next + 2'd1;
        end else begin
          color       = {b, cbytes_next};
          phase_next  = '0;
          cbytes_next = '0;
          if (!mode.rle_mode || is_raw_next) begin
            push       = 1'b1;
            push_color = color;
            push_col   = col_next;
            push_row   = row_next;
            ps         = advance(col_next, row_next);
            col_next   = ps.col;
            row_next   = ps.row;
            done_next  = ps.done;
            if (ps.done) begin
              left_next     = '0;
              want_hdr_next = 1'b1;
              run_pend_next = 1'b0;
            end
            if (mode.rle_mode) begin
              if (left_next != '0) begin
                left_next = left_next - 8'd1;
              end
              if (left_next == '0) begin
                want_hdr_next = 1'b1;
              end
            end
          end else begin
            held_next  = color;
            n_next     = '0;
            state_next = S_RUN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ACCEPT;
      phase    <= '0;
      cbytes   <= '0;
      held     <= '0;
      left     <= '0;
      is_raw   <= 1'b0;
      want_hdr <= 1'b1;
      run_pend <= 1'b0;
      done     <= 1'b0;
      col      <= '0;
      row      <= '0;
      n        <= '0;
      pend_v   <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      cbytes   <= cbytes_next;
      held     <= held_next;
      left     <= left_next;
      is_raw   <= is_raw_next;
      want_hdr <= want_hdr_next;
      run_pend <= run_pend_next;
      done     <= done_next;
      col      <= col_next;
      row      <= row_next;
      n        <= n_next;
      pend_v   <= pend_v_next;
    end
    pend_byte <= pend_byte_next;
    pend_sof  <= pend_sof_next;
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("tgad_front: pixel issued into full queue");
  assert property (@(posedge clk) disable iff (rst) n <= RUN_CAP_N)
    else $error("tgad_front: run copies beyond cap in one byte");
  assert property (@(posedge clk) disable iff (rst) (state == S_HOLD) |-> pend_v)
    else $error("tgad_front: hold state without a parked byte");

endmodule

@@ sv/tgad_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgad_back
// pixel back end: mirroring, row flip, last flag and output register
// ----------------------------------------------------------------------------
module tgad_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tgad_pkg::mode_t            mode,
  input  logic [COORD_BITS:0]        eff_w,
  input  logic [COORD_BITS:0]        eff_h,
  input  logic                       q_empty,
  input  logic [31+2*COORD_BITS:0]   q_data,
  output logic                       q_rd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [55:0]                out_data,
  output logic                       out_last
);

  import tgad_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 1;

  logic [31:0]             q_color;
  logic [CB-1:0]           q_col;
  logic [CB-1:0]           q_row;
  logic [EW-1:0]           xf;
  logic [EW-1:0]           yf;
  logic [OUT_COORD_BITS-1:0] x_out;
  logic [OUT_COORD_BITS-1:0] y_out;
  logic                    last;

  assign q_color = q_data[31:0];
  assign q_col   = q_data[31+CB:32];
  assign q_row   = q_data[31+2*CB:32+CB];

  always_comb begin
    xf    = mode.mirror_x ? (eff_w - EW'(1) - EW'(q_col)) : EW'(q_col);
    yf    = mode.mirror_y ? EW'(q_row) : (eff_h - EW'(1) - EW'(q_row));
    x_out = OUT_COORD_BITS'(xf[CB-1:0]);
    y_out = OUT_COORD_BITS'(yf[CB-1:0]);
    last  = ((EW'(q_col) + EW'(1)) >= eff_w) && ((EW'(q_row) + EW'(1)) >= eff_h);
  end

  assign q_rd = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !q_empty;
    end
    if (q_rd) begin
      out_data <= {y_out, x_out, q_color};
      out_last <= last;
    end
  end

endmodule

@@ sv/tga_rle_pixel_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// decodes the pixel data section of a 32-bit truecolor tga image
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one data byte per transaction; tuser marks the first byte
//   of a frame and clears position and packet state before that byte
//   m_axis carries one pixel per transaction: colour, destination x and y,
//   and tlast on the final pixel of the image; bytes after it are dropped
//   until the next frame start
//   cfg_we/cfg_index/cfg_data set size, rle mode and mirroring while idle
// timing
//   a byte is taken every cycle while the pixel queue has room and no run
//   copies are being issued; the pixel that a fourth colour byte completes
//   goes through the pixel queue and the output register to m_axis
//   a run packet issues one copy per cycle from the front end run counter
//   while the queue has room and holds s_axis; at most 64 copies follow one
//   byte, the rest go out when the next byte arrives
// reset and stalls
//   rst (synchronous) clears all frame state and sets 1 x 1, uncompressed
//   a stalled m_axis fills the output register, then the queue, then
//   s_axis tready drops; nothing is lost
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int COORD_BITS = tgad_pkg::COORD_BITS_DEF,
  parameter int FIFO_DEPTH = tgad_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // byte stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  logic                              s_axis_tuser,  // [0] frame_start
  // pixel stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [55:0]                       m_axis_tdata,  // [31:0] pixel_color,
                                                           // [43:32] pixel_x,
                                                           // [55:44] pixel_y
  output logic                              m_axis_tlast,  // last_pixel
  // configuration writes
  input  logic                              cfg_we,
  input  logic [tgad_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tgad_pkg::CFG_BITS-1:0]     cfg_data
);

  import tgad_pkg::*;

  localparam int EW = COORD_BITS + 1;
  // compare width for size saturation
  localparam int CW = (COORD_BITS + 1 > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS;
  localparam int QW = 32 + 2 * COORD_BITS;

  // effective sizes kept already clamped to 1 .. 2^COORD_BITS
  logic [EW-1:0]         eff_w;
  logic [EW-1:0]         eff_h;
  mode_t                 mode;

  logic                  push;
  logic [31:0]           push_color;
  logic [COORD_BITS-1:0] push_col;
  logic [COORD_BITS-1:0] push_row;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_rd;
  logic [QW-1:0]         q_data;

  function automatic logic [EW-1:0] eff_size(input logic [CFG_BITS-1:0] v);
    logic [CW-1:0] ve;
    logic [CW-1:0] lim;
    ve  = CW'(v);
    lim = CW'(1) << COORD_BITS;
    if (ve == '0) begin
      return EW'(1);
    end
    if (ve > lim) begin
      return EW'(lim);
    end
    return EW'(ve);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= EW'(1);
      eff_h <= EW'(1);
      mode  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  eff_w         <= eff_size(cfg_data);
        CFG_IMAGE_HEIGHT: eff_h         <= eff_size(cfg_data);
        CFG_RLE_MODE:     mode.rle_mode <= cfg_data[0];
        CFG_MIRROR_X:     mode.mirror_x <= cfg_data[0];
        CFG_MIRROR_Y:     mode.mirror_y <= cfg_data[0];
        default:          mode          <= mode;   // unused indexes ignored
      endcase
    end
  end

  // front end: byte classification, colour assembly, runs and raster count
  tgad_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_sof     (s_axis_tuser),
    .q_full     (q_full),
    .push       (push),
    .push_color (push_color),
    .push_col   (push_col),
    .push_row   (push_row)
  );

  // pixel queue decoupling the two halves
  tgad_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data ({push_row, push_col, push_color}),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // back end: coordinate mapping and output register
  tgad_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tga rle pixel decoder
// ----------------------------------------------------------------------------
// a queue of data bytes feeds a clocked driver on s_axis; each accepted byte
// goes through a cycle-free model of the decoder, which queues the pixels it
// produces; a clocked monitor on m_axis checks every pixel against the oldest
// queued one; a short directed opening is followed by random phases, each
// with its own size, mode and mirroring, written while the decoder is idle
// ----------------------------------------------------------------------------
module tb_top;
  import tgad_pkg::*;

  localparam int BYTES_PER_PIXEL = 4;
  localparam int IDLE_PERCENT    = 18;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_SPACING    = 270;   // accepted bytes between long holds
  localparam int STALL_LIMIT     = 5000;  // cycles without any transaction
  localparam int DRAIN_CYCLES    = 16;
  localparam int TARGET_BYTES    = 525;
  localparam int FRAME_BUDGET    = 24;    // pixel budget of a frame; a closing run may overrun it

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
  } byte_item_t;

  typedef struct packed {
    logic [31:0]               colour;
    logic [OUT_COORD_BITS-1:0] x;
    logic [OUT_COORD_BITS-1:0] y;
    logic                      is_last;
  } pixel_t;

  // dut ports; the bench-driven ones are known from time zero
  logic                    clk;
  logic                    rst            = 1'b1;
  logic                    s_axis_tvalid  = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata   = '0;
  logic                    s_axis_tuser   = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready  = 1'b0;
  logic [55:0]             m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_we         = 1'b0;
  cfg_idx_t                cfg_index      = CFG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0]     cfg_data       = '0;

  // bench bookkeeping
  byte_item_t byte_q[$];
  pixel_t     expected_pixels[$];
  int         fail_count   = 0;
  int         bytes_pushed = 0;
  int         cycle_count  = 0;

  // model copy of the registers
  logic [12:0] width_reg    = 13'd1;
  logic [12:0] height_reg   = 13'd1;
  logic        rle_reg      = 1'b0;
  logic        mirror_x_reg = 1'b0;
  logic        mirror_y_reg = 1'b0;

  // model copy of the frame state
  logic [1:0]  phase_r        = '0;
  logic [23:0] partial_colour = '0;
  logic [31:0] run_colour     = '0;
  logic [7:0]  copies_left    = '0;
  logic        raw_packet     = 1'b0;
  logic        header_due     = 1'b1;
  logic        run_pending    = 1'b0;
  logic        frame_over     = 1'b0;
  logic [11:0] col_r          = '0;
  logic [11:0] row_r          = '0;

  tga_rle_pixel_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] frame_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] colour, [43:32] x, [55:44] y
    .m_axis_tlast  (m_axis_tlast),   // last pixel of the image
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // zero size counts as one, oversize saturates at the counter range
  function automatic int unsigned eff_dim(logic [12:0] v);
    if (v == 0) return 1;
    if (v > (1 << COORD_BITS_DEF)) return 1 << COORD_BITS_DEF;
    return 32'(v);
  endfunction

  function automatic void clear_position();
    phase_r        = '0;
    partial_colour = '0;
    run_colour     = '0;
    copies_left    = '0;
    raw_packet     = 1'b0;
    header_due     = 1'b1;
    run_pending    = 1'b0;
    frame_over     = 1'b0;
    col_r          = '0;
    row_r          = '0;
  endfunction

  // place one pixel, then step the raster position
  function automatic void emit_pixel(logic [31:0] colour);
    int unsigned w, h, c, r, x, y;
    logic        is_last;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    c = 32'(col_r);
    r = 32'(row_r);
    // default storage is bottom-up, so rows flip unless mirror_y is set
    x = mirror_x_reg ? w - 1 - c : c;
    y = mirror_y_reg ? r : h - 1 - r;
    is_last = (c + 1 >= w) && (r + 1 >= h);
    expected_pixels.push_back('{colour: colour, x: x[11:0], y: y[11:0], is_last: is_last});
    col_r = col_r + 12'd1;
    if (col_r == 0 || col_r >= w) begin
      col_r = '0;
      row_r = row_r + 12'd1;
      if (row_r == 0 || row_r >= h) frame_over = 1'b1;
    end
    // image end drops whatever packet was in flight
    if (frame_over) begin
      copies_left    = '0;
      header_due     = 1'b1;
      run_pending    = 1'b0;
      phase_r        = '0;
      partial_colour = '0;
    end
  endfunction

  // issue run copies up to the per-byte cap, n counts those already issued
  function automatic int flush_run(int n);
    while (copies_left != 0 && n < RUN_CAP && !frame_over) begin
      emit_pixel(run_colour);
      n++;
      if (copies_left != 0) copies_left--;
    end
    if (frame_over || copies_left == 0) begin
      copies_left = '0;
      header_due  = 1'b1;
      run_pending = 1'b0;
    end else begin
      run_pending = 1'b1;
    end
    return n;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fs);
    int          n;
    logic [31:0] colour;
    n = 0;
    // leftover copies of a long run go out before this byte is looked at
    if (run_pending) n = flush_run(n);
    if (fs) clear_position();
    if (frame_over) return;
    if (rle_reg && header_due) begin
      raw_packet     = (b <= RAW_MAX);
      copies_left    = raw_packet ? b + 8'd1 : b - 8'(RAW_MAX);
      header_due     = 1'b0;
      phase_r        = '0;
      partial_colour = '0;
      return;
    end
    if (phase_r < 3) begin
      if (phase_r == 0) partial_colour = '0;
      partial_colour[8*phase_r +: 8] = b;
      phase_r++;
      return;
    end
    colour         = {b, partial_colour};
    phase_r        = '0;
    partial_colour = '0;
    if (!rle_reg) begin
      emit_pixel(colour);
      return;
    end
    if (raw_packet) begin
      emit_pixel(colour);
      if (copies_left != 0) copies_left--;
      if (copies_left == 0) header_due = 1'b1;
      return;
    end
    run_colour = colour;
    n = flush_run(n);
  endfunction

  // ---------------------------------------------------------------- timing helpers

  // long stretches with no idling on either side
  function automatic logic may_idle();
    return (cycle_count % 1000) < 700;
  endfunction

  // cycle counter and no-progress watchdog
  always @(posedge clk) begin : watchdog
    int stall_cycles;
    cycle_count <= cycle_count + 1;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d pixels outstanding",
                 $time, stall_cycles, expected_pixels.size());
        $display("tga_rle_pixel_decoder test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- byte driver

  always @(posedge clk) begin : drive_bytes
    byte_item_t nxt;
    logic       offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser);
        offer = 1'b0;
      end
      // a held byte stays until taken; gaps only fall between bytes
      if (!offer && byte_q.size() != 0 &&
          !(may_idle() && $urandom_range(99) < IDLE_PERCENT)) begin
        nxt = byte_q.pop_front();
        s_axis_tdata <= nxt.data;
        s_axis_tuser <= nxt.fs;
        offer = 1'b1;
      end
      s_axis_tvalid <= offer;
    end
  end

  // ---------------------------------------------------------------- pixel sink

  // random back-pressure, plus long holds so the pixel queue fills up and
  // the byte side stalls
  always @(posedge clk) begin : drive_ready
    int bytes_seen;
    int hold_left;
    int next_hold_at;
    if (rst) begin
      bytes_seen    = 0;
      hold_left     = 0;
      next_hold_at  = 150;
      m_axis_tready <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) bytes_seen++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (bytes_seen >= next_hold_at) begin
        hold_left    = HOLD_CYCLES;
        next_hold_at = next_hold_at + HOLD_SPACING;
      end
      m_axis_tready <= (hold_left == 0) &&
                       !(may_idle() && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{colour: m_axis_tdata[31:0], x: m_axis_tdata[43:32],
              y: m_axis_tdata[55:44], is_last: m_axis_tlast};
      if (expected_pixels.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected pixel colour %h x %0d y %0d last %b",
                 $time, got.colour, got.x, got.y, got.is_last);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: pixel mismatch expected colour %h x %0d y %0d last %b",
                   $time, want.colour, want.x, want.y, want.is_last);
          $display("%0t:                  actual colour %h x %0d y %0d last %b",
                   $time, got.colour, got.x, got.y, got.is_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(logic [7:0] b, logic fs);
    byte_q.push_back('{data: b, fs: fs});
    bytes_pushed++;
  endtask

  // four colour bytes, lowest first; fs only marks the first of them
  task automatic push_pixel(logic fs);
    push_byte(8'($urandom), fs);
    repeat (BYTES_PER_PIXEL - 1) push_byte(8'($urandom), 1'b0);
  endtask

  // register write through one cfg_we strobe; model copy is updated at the edge that takes it
  task automatic write_reg(cfg_idx_t idx, logic [12:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg    = val;
      CFG_IMAGE_HEIGHT: height_reg   = val;
      CFG_RLE_MODE:     rle_reg      = val[0];
      CFG_MIRROR_X:     mirror_x_reg = val[0];
      CFG_MIRROR_Y:     mirror_y_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [12:0] w, logic [12:0] h, logic rle, logic mx, logic my);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_RLE_MODE, {12'd0, rle});
    write_reg(CFG_MIRROR_X, {12'd0, mx});
    write_reg(CFG_MIRROR_Y, {12'd0, my});
  endtask

  // wait for every byte taken and every pixel seen, then let the pipe empty;
  // a run still waiting for its next byte gets one so nothing is left inside
  task automatic settle();
    do begin
      while (byte_q.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0) begin
        @(posedge clk);
        #1;
      end
      if (run_pending) push_byte(8'($urandom), 1'($urandom_range(1)));
    end while (byte_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one frame: well formed packets with random content, occasionally cut
  // short or followed by stray bytes
  task automatic make_frame(int unsigned budget);
    int unsigned total, left, n, k, roll;
    logic        fs;
    total = eff_dim(width_reg) * eff_dim(height_reg);
    left  = (total < budget) ? total : budget;
    fs    = 1'b1;
    if (!rle_reg) begin
      if ($urandom_range(9) == 0) left = $urandom_range(left);
      repeat (left) begin
        push_pixel(fs);
        fs = 1'b0;
      end
    end else begin
      while (left > 0) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          // raw packet abandoned partway, the next frame start clears it
          n = $urandom_range(0, RAW_MAX);
          push_byte(8'(n), fs);
          fs = 1'b0;
          k = $urandom_range(0, (n < 3) ? n : 3);
          repeat (k) push_pixel(1'b0);
          left = 0;
        end else if (roll < 50) begin
          n = $urandom_range(1, (left < 6) ? left : 6);
          push_byte(8'(n - 1), fs);
          fs = 1'b0;
          repeat (n) push_pixel(1'b0);
          left = left - n;
        end else begin
          // runs may be long, and may overrun the end of the image
          n = (roll < 62) ? $urandom_range(60, 128) : $urandom_range(1, 8);
          push_byte(8'(n + RAW_MAX), fs);
          fs = 1'b0;
          push_pixel(1'b0);
          left = (n >= left) ? 0 : left - n;
        end
      end
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic pick_config(int phase_no);
    logic [12:0] w, h;
    int          sel;
    w   = 13'($urandom_range(1, 6));
    h   = 13'($urandom_range(1, 4));
    sel = $urandom_range(9);
    case (sel)
      0: w = 13'd0;
      1: h = 13'd0;
      2: w = 13'($urandom);
      3: w = 13'd4096;
      default: ;
    endcase
    // tallest image, one pixel per row, so the row flip reaches the top row
    if (phase_no == 0) begin
      w = 13'd1;
      h = 13'd4096;
    end
    write_all(w, h, (phase_no == 0) ? 1'b1 : 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    int phase_no;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 1 x 1 uncompressed, every pixel ends the image
    push_byte(8'h00, 1'b1);
    repeat (3) push_byte(8'h00, 1'b0);
    repeat (4) push_byte(8'hff, 1'b0);          // after image end, ignored
    push_byte(8'hff, 1'b1);
    repeat (3) push_byte(8'hff, 1'b0);
    push_byte(8'h11, 1'b1);                     // leave a partial pixel behind
    push_byte(8'h22, 1'b0);
    settle();

    // width above range saturates, zero height counts as one; switched to
    // rle mid frame, so the header byte must drop the partial pixel
    write_all(13'h1fff, 13'd0, 1'b1, 1'b1, 1'b0);
    push_byte(8'hff, 1'b0);                     // run of 128, over the cap
    push_pixel(1'b0);
    push_byte(8'h80, 1'b0);                     // carries the leftover copies
    push_pixel(1'b0);
    push_byte(8'h7f, 1'b0);                     // largest raw packet
    push_pixel(1'b0);
    settle();

    phase_no = 0;
    while (bytes_pushed < TARGET_BYTES) begin
      pick_config(phase_no);
      repeat ($urandom_range(1, 3)) make_frame(FRAME_BUDGET);
      // noise, now and then with a frame start in the middle of it
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom), $urandom_range(3) == 0);
      end
      settle();
      phase_no++;
    end

    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("tga_rle_pixel_decoder test passed");
    end else begin
      $display("tga_rle_pixel_decoder test failed");
    end
    $finish;
  end

endmodule
